[hdl/assert_macros.svh]
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HLMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define HLMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define HLMD_ASSERT(lbl, prop, msg)
`define HLMD_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[hdl/hlmd_pkg.sv]
// Shared types, constants and name tables of the header-length message deframer.
package hlmd_pkg;

    localparam int MAX_TYPE_LEN = 32;
    localparam int LENGTH_BITS  = 32;
    localparam int TYPE_LEN_W   = $clog2(MAX_TYPE_LEN + 1);
    localparam int TYPE_ADDR_W  = (MAX_TYPE_LEN > 1) ? $clog2(MAX_TYPE_LEN) : 1;
    localparam logic [TYPE_LEN_W-1:0] TYPE_MAX_CNT = TYPE_LEN_W'(MAX_TYPE_LEN);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [3:0] NAME_A_LEN   = 4'd12;
    localparam logic [3:0] NAME_B_LEN   = 4'd14;
    localparam logic [3:0] NAME_POS_MAX = 4'd15;

    typedef struct packed {
        logic                  is_type;
        logic [7:0]            data;
        logic                  last;
        logic                  trunc;
        logic [TYPE_LEN_W-1:0] tlen;
    } cmd_t;

    typedef struct packed {
        logic                   we;
        logic [TYPE_ADDR_W-1:0] addr;
        logic [7:0]             data;
    } type_wr_t;

    function automatic logic [7:0] name_a_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "M";
            4'd1:    c = "e";
            4'd2:    c = "s";
            4'd3:    c = "s";
            4'd4:    c = "a";
            4'd5:    c = "g";
            4'd6:    c = "e";
            4'd7:    c = "-";
            4'd8:    c = "T";
            4'd9:    c = "y";
            4'd10:   c = "p";
            4'd11:   c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] name_b_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/hlmd_front.sv]
// Front end: header parser that classifies received bytes and queues output commands.
`include "assert_macros.svh"
module hlmd_front import hlmd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data,
    output type_wr_t   type_wr,
    input  logic       type_done
);

    typedef enum logic [2:0] {PH_READY, PH_HEADER, PH_BODY} phase_t;

    localparam logic [1:0] DOK_NONE = 2'd0;
    localparam logic [1:0] DOK_IN   = 2'd1;
    localparam logic [1:0] DOK_END  = 2'd2;
    localparam logic [1:0] DOK_BAD  = 2'd3;
    localparam int WIDE_W = LENGTH_BITS + 4;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             flags_reg, flags_next;
    logic [3:0]             npos_reg, npos_next;
    logic                   inv_reg, inv_next;
    logic                   ats_reg, ats_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [1:0]             dok_reg, dok_next;
    logic [LENGTH_BITS-1:0] clen_reg, clen_next;
    logic [TYPE_LEN_W-1:0]  tlen_reg, tlen_next;
    logic                   tovf_reg, tovf_next;
    logic [LENGTH_BITS-1:0] brem_reg, brem_next;
    logic                   pend_reg, pend_next;

    logic                   fire;
    logic [7:0]             b;
    logic [1:0]             cur_flags;
    logic [3:0]             cur_npos;
    logic                   cur_inv;
    logic                   cur_ats;
    logic [LENGTH_BITS-1:0] cur_acc;
    logic [1:0]             cur_dok;
    logic                   digit;
    logic [WIDE_W-1:0]      acc_wide;

    assign s_tready = !q_full && !pend_reg;
    assign fire     = s_tvalid && s_tready;
    assign b        = s_tdata;

    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        npos_next  = npos_reg;
        inv_next   = inv_reg;
        ats_next   = ats_reg;
        acc_next   = acc_reg;
        dok_next   = dok_reg;
        clen_next  = clen_reg;
        tlen_next  = tlen_reg;
        tovf_next  = tovf_reg;
        brem_next  = brem_reg;
        pend_next  = pend_reg && !type_done;
        q_push     = 1'b0;
        q_data     = '0;
        type_wr    = '0;

        if (phase_reg == PH_HEADER) begin
            cur_flags = flags_reg;
            cur_npos  = npos_reg;
            cur_inv   = inv_reg;
            cur_ats   = ats_reg;
            cur_acc   = acc_reg;
            cur_dok   = dok_reg;
        end else begin
            cur_flags = 2'b11;
            cur_npos  = '0;
            cur_inv   = 1'b0;
            cur_ats   = 1'b0;
            cur_acc   = '0;
            cur_dok   = DOK_NONE;
        end
        digit    = (b >= CH_0) && (b <= CH_9);
        acc_wide = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1)
                 + {{(WIDE_W-4){1'b0}}, 4'(b - CH_0)};

        if (fire) begin
            if (phase_reg == PH_BODY) begin
                if (brem_reg != '0) begin
                    if (tlen_reg != '0) begin
                        q_push       = 1'b1;
                        q_data.data  = b;
                        q_data.last  = (brem_reg == LENGTH_BITS'(1));
                        q_data.trunc = tovf_reg;
                    end
                end
                if (brem_reg <= LENGTH_BITS'(1)) begin
                    brem_next  = '0;
                    tlen_next  = '0;
                    tovf_next  = 1'b0;
                    clen_next  = '0;
                    phase_next = PH_READY;
                end else begin
                    brem_next = brem_reg - LENGTH_BITS'(1);
                end
            end else if (phase_reg != PH_HEADER && b == CH_LF) begin
                phase_next = phase_reg;
            end else begin
                phase_next = PH_HEADER;
                flags_next = cur_flags;
                npos_next  = cur_npos;
                inv_next   = cur_inv;
                ats_next   = cur_ats;
                acc_next   = cur_acc;
                dok_next   = cur_dok;
                if (b == CH_LF) begin
                    if (!cur_inv && cur_npos == '0) begin
                        if (clen_reg != '0) begin
                            brem_next  = clen_reg;
                            phase_next = PH_BODY;
                            if (tlen_reg != '0) begin
                                q_push         = 1'b1;
                                q_data.is_type = 1'b1;
                                q_data.trunc   = tovf_reg;
                                q_data.tlen    = tlen_reg;
                                pend_next      = 1'b1;
                            end
                        end else begin
                            phase_next = PH_READY;
                        end
                    end else if (cur_inv && cur_flags[1]
                                 && (cur_dok == DOK_IN || cur_dok == DOK_END)) begin
                        clen_next = cur_acc;
                    end
                    flags_next = 2'b11;
                    npos_next  = '0;
                    inv_next   = 1'b0;
                    ats_next   = 1'b0;
                    acc_next   = '0;
                    dok_next   = DOK_NONE;
                end else if (!cur_inv) begin
                    if (b == CH_COLON) begin
                        flags_next[0] = cur_flags[0] && (cur_npos == NAME_A_LEN);
                        flags_next[1] = cur_flags[1] && (cur_npos == NAME_B_LEN);
                        inv_next      = 1'b1;
                        ats_next      = 1'b1;
                        if (cur_flags[0] && (cur_npos == NAME_A_LEN)) begin
                            tlen_next = '0;
                            tovf_next = 1'b0;
                        end
                    end else begin
                        if (!(cur_npos < NAME_A_LEN && b == name_a_char(cur_npos))) begin
                            flags_next[0] = 1'b0;
                        end
                        if (!(cur_npos < NAME_B_LEN && b == name_b_char(cur_npos))) begin
                            flags_next[1] = 1'b0;
                        end
                        if (cur_npos < NAME_POS_MAX) begin
                            npos_next = cur_npos + 4'd1;
                        end
                    end
                end else if (cur_ats && b == CH_SPACE) begin
                    ats_next = 1'b0;
                end else begin
                    ats_next = 1'b0;
                    if (cur_flags[0]) begin
                        if (tlen_reg < TYPE_MAX_CNT) begin
                            type_wr.we   = 1'b1;
                            type_wr.addr = tlen_reg[TYPE_ADDR_W-1:0];
                            type_wr.data = b;
                            tlen_next    = tlen_reg + TYPE_LEN_W'(1);
                        end else begin
                            tovf_next = 1'b1;
                        end
                    end
                    if (cur_flags[1]) begin
                        if (cur_dok == DOK_NONE) begin
                            dok_next = digit ? DOK_IN : DOK_BAD;
                        end else if (cur_dok == DOK_IN && !digit) begin
                            dok_next = DOK_END;
                        end
                        if (dok_next == DOK_IN && digit) begin
                            if (acc_wide[WIDE_W-1:LENGTH_BITS] != '0) begin
                                dok_next = DOK_BAD;
                            end else begin
                                acc_next = acc_wide[LENGTH_BITS-1:0];
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_READY;
            flags_reg <= 2'b11;
            npos_reg  <= '0;
            inv_reg   <= 1'b0;
            ats_reg   <= 1'b0;
            acc_reg   <= '0;
            dok_reg   <= DOK_NONE;
            clen_reg  <= '0;
            tlen_reg  <= '0;
            tovf_reg  <= 1'b0;
            brem_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            npos_reg  <= npos_next;
            inv_reg   <= inv_next;
            ats_reg   <= ats_next;
            acc_reg   <= acc_next;
            dok_reg   <= dok_next;
            clen_reg  <= clen_next;
            tlen_reg  <= tlen_next;
            tovf_reg  <= tovf_next;
            brem_reg  <= brem_next;
            pend_reg  <= pend_next;
        end
    end

    `HLMD_ASSERT_IMP(a_pend_in_body, pend_reg, phase_reg == PH_BODY, "type run pending outside body")
    `HLMD_ASSERT_IMP(a_tlen_bound, 1'b1, tlen_reg <= TYPE_MAX_CNT, "type length beyond store")

endmodule

[hdl/hlmd_fifo.sv]
// Short command queue between the parser and the output sequencer.
`include "assert_macros.svh"
module hlmd_fifo import hlmd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

    `HLMD_ASSERT_IMP(a_no_push_full, push, !full, "request pushed into full queue")

endmodule

[hdl/hlmd_back.sv]
// Back end: type store and output sequencer that emits type runs and body bytes.
`include "assert_macros.svh"
module hlmd_back import hlmd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  type_wr_t    type_wr,
    input  logic        q_empty,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        type_done,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_t;

    logic [7:0]            store_mem [MAX_TYPE_LEN];
    logic [7:0]            rd_data_reg;
    state_t                state_reg;
    logic [TYPE_LEN_W-1:0] idx_reg;
    logic [TYPE_LEN_W-1:0] len_reg;
    logic                  trunc_reg;
    logic                  done_reg;
    logic                  valid_reg;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic                  otrunc_reg;
    logic                  kind_reg;
    logic                  out_free;
    logic                  type_last;
    logic                  out_load;

    assign out_free  = !valid_reg || m_tready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign type_last = (idx_reg + TYPE_LEN_W'(1) == len_reg);
    assign out_load  = (q_pop && !q_data.is_type) || ((state_reg == ST_EMIT) && out_free);
    assign type_done = done_reg;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {7'b0, otrunc_reg, byte_reg};
    assign m_tlast   = last_reg;
    assign m_tuser   = kind_reg;

    always_ff @(posedge aclk) begin
        if (type_wr.we) begin
            store_mem[type_wr.addr] <= type_wr.data;
        end
        rd_data_reg <= store_mem[idx_reg[TYPE_ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == ST_EMIT) && out_free && type_last;
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        if (q_data.is_type) begin
                            len_reg   <= q_data.tlen;
                            trunc_reg <= q_data.trunc;
                            idx_reg   <= '0;
                            state_reg <= ST_READ;
                        end else begin
                            kind_reg   <= 1'b1;
                            byte_reg   <= q_data.data;
                            last_reg   <= q_data.last;
                            otrunc_reg <= q_data.trunc;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        kind_reg   <= 1'b0;
                        byte_reg   <= rd_data_reg;
                        last_reg   <= type_last;
                        otrunc_reg <= trunc_reg;
                        if (type_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + TYPE_LEN_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `HLMD_ASSERT_IMP(a_idx_in_run, state_reg != ST_IDLE, idx_reg < len_reg, "type index past run")
    `HLMD_ASSERT_IMP(a_done_last, done_reg, valid_reg && last_reg && !kind_reg, "done without last type byte")

endmodule

[hdl/header_length_message_deframer.sv]
// A body byte passes through the command queue and the output register to the m_ side.
// Header and body bytes are taken one byte per cycle while the command queue is not full;
// at the end of the headers the input holds off while the type run drains from the type store.
// The type store read port and its registered read data set the type run pace.
// Reset: synchronous active-low aresetn clears parser, queue and output control;
// the type store holds no reset; only entries written for the current run are emitted.
module header_length_message_deframer import hlmd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] type_truncated, [15:9] zero
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // item_kind
);

    logic     q_full;
    logic     q_push;
    cmd_t     q_in;
    logic     q_pop;
    cmd_t     q_out;
    logic     q_empty;
    type_wr_t type_wr;
    logic     type_done;

    hlmd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in),
        .type_wr   (type_wr),
        .type_done (type_done)
    );

    hlmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    hlmd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .type_wr   (type_wr),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .type_done (type_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

[dv/header_length_message_deframer_tb.sv]
// Testbench for the header-length message deframer: directed and random framed byte streams.
`timescale 1ns / 1ps

module header_length_message_deframer_tb;
    import hlmd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_REQS   = 360;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 16;
    localparam int REPORT_MAX    = 10;
    localparam logic [8*12-1:0] TYPE_NAME = "Message-Type";
    localparam logic [8*14-1:0] LEN_NAME  = "Content-Length";
    localparam logic [63:0]     LEN_MAX   = {64{1'b1}} >> (64 - LENGTH_BITS);

    typedef enum logic [1:0] {PH_IDLE, PH_HDR, PH_BODY} phase_e;
    typedef enum logic [1:0] {LS_NONE, LS_DIGITS, LS_DONE, LS_BAD} len_state_e;
    typedef enum int {LN_TYPE, LN_LENGTH, LN_NEAR, LN_JUNK, LN_NOISE} line_e;
    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } deframe_out_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       quiet;
    } probe_row_t;

    // quiet rows expect no result: nothing is emitted while the length stays zero
    localparam probe_row_t PROBE_TAB [24] = '{
        '{CH_LF, 1'b1},    '{CH_LF, 1'b1},    '{8'h00, 1'b1},    '{8'hFF, 1'b1},
        '{CH_COLON, 1'b1}, '{CH_SPACE, 1'b1}, '{8'hFF, 1'b1},    '{8'h00, 1'b1},
        '{CH_LF, 1'b1},    '{8'h78, 1'b1},    '{CH_LF, 1'b1},    '{CH_COLON, 1'b1},
        '{CH_LF, 1'b1},    '{8'h4D, 1'b1},    '{CH_COLON, 1'b1}, '{CH_LF, 1'b1},
        '{8'hAA, 1'b1},    '{8'h55, 1'b1},    '{CH_COLON, 1'b1}, '{8'h7F, 1'b1},
        '{8'h80, 1'b1},    '{CH_LF, 1'b1},    '{CH_LF, 1'b1},    '{CH_LF, 1'b1}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    phase_e       hdr_phase = PH_IDLE;
    logic [1:0]   name_hits = 2'b11;
    logic [3:0]   name_idx = '0;
    logic         val_seen = 1'b0;
    logic         val_first = 1'b0;
    logic [63:0]  len_acc = '0;
    len_state_e   len_st = LS_NONE;
    logic [63:0]  frame_len = '0;
    logic [7:0]   type_buf [MAX_TYPE_LEN];
    int           type_cnt = 0;
    logic         type_cut = 1'b0;
    logic [63:0]  body_left = '0;

    deframe_out_t byte_out [$];
    deframe_out_t pending_out [$];

    int       cycle_cnt = 0;
    int       mismatches = 0;
    int       type_seen = 0;
    int       body_seen = 0;
    int       dir_reqs = 0;
    int       rand_reqs = 0;
    int       frames = 0;
    int       burst_left = 0;
    bit       in_random = 1'b0;
    bit       hold_go = 1'b0;
    int       hold_left = 0;
    rx_mode_e rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       rx_tick = 0;

    string near_names [6] = '{"Message-Typ", "message-Type", "Content-Lengthh",
                              "Content-Length ", "Content-Type", "Message-Type-Content-Length"};

    header_length_message_deframer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_out.size());
            $display("FAIL header_length_message_deframer");
            $finish;
        end
    end

    function automatic void clear_line();
        name_hits = 2'b11;
        name_idx  = '0;
        val_seen  = 1'b0;
        val_first = 1'b0;
        len_acc   = '0;
        len_st    = LS_NONE;
    endfunction

    function automatic void emit(input logic kind, input logic [7:0] data, input logic last);
        byte_out.push_back('{kind: kind, data: data, last: last, trunc: type_cut});
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [1:0]  hits;
        logic        digit;
        logic [63:0] d;
        byte_out.delete();
        if (hdr_phase == PH_BODY) begin
            if (body_left != 0) begin
                if (type_cnt != 0)
                    emit(1'b1, b, body_left == 1);
                body_left--;
            end
            if (body_left == 0) begin
                type_cnt  = 0;
                type_cut  = 1'b0;
                frame_len = '0;
                hdr_phase = PH_IDLE;
            end
            return;
        end
        if (hdr_phase != PH_HDR) begin
            if (b == CH_LF)
                return;
            hdr_phase = PH_HDR;
            clear_line();
        end
        if (b == CH_LF) begin
            if (!val_seen && name_idx == 0) begin
                if (frame_len != 0) begin
                    body_left = frame_len;
                    hdr_phase = PH_BODY;
                    for (int i = 0; i < type_cnt; i++)
                        emit(1'b0, type_buf[i], i + 1 == type_cnt);
                end else begin
                    hdr_phase = PH_IDLE;
                end
            end else if (val_seen && name_hits[1] && (len_st == LS_DIGITS || len_st == LS_DONE)) begin
                frame_len = len_acc;
            end
            clear_line();
            return;
        end
        if (!val_seen) begin
            if (b == CH_COLON) begin
                hits = 2'b00;
                hits[0] = name_hits[0] && name_idx == 4'd12;
                hits[1] = name_hits[1] && name_idx == 4'd14;
                name_hits = hits;
                val_seen  = 1'b1;
                val_first = 1'b1;
                if (hits[0]) begin
                    type_cnt = 0;
                    type_cut = 1'b0;
                end
            end else begin
                if (!(name_idx < 12 && b == TYPE_NAME[8*(11 - name_idx) +: 8]))
                    name_hits[0] = 1'b0;
                if (!(name_idx < 14 && b == LEN_NAME[8*(13 - name_idx) +: 8]))
                    name_hits[1] = 1'b0;
                if (name_idx != 4'd15)
                    name_idx++;
            end
            return;
        end
        if (val_first) begin
            val_first = 1'b0;
            if (b == CH_SPACE)
                return;
        end
        if (name_hits[0]) begin
            if (type_cnt < MAX_TYPE_LEN) begin
                type_buf[type_cnt] = b;
                type_cnt++;
            end else begin
                type_cut = 1'b1;
            end
        end
        if (name_hits[1]) begin
            digit = b >= CH_0 && b <= CH_9;
            if (len_st == LS_NONE)
                len_st = digit ? LS_DIGITS : LS_BAD;
            else if (len_st == LS_DIGITS && !digit)
                len_st = LS_DONE;
            if (len_st == LS_DIGITS && digit) begin
                d = 64'(b - CH_0);
                if (len_acc > (LEN_MAX - d) / 10)
                    len_st = LS_BAD;
                else
                    len_acc = len_acc * 10 + d;
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit predict);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (!(b == CH_LF && hdr_phase == PH_IDLE)) begin
            if (in_random)
                rand_reqs++;
            else
                dir_reqs++;
        end
        deframe_byte(b);
        if (predict)
            foreach (byte_out[i]) pending_out.push_back(byte_out[i]);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b1);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == CH_LF)
            v = 8'h0B;
        return v;
    endfunction

    task automatic send_line(input line_e kind);
        int         n;
        string      val;
        logic [7:0] v;
        case (kind)
            LN_TYPE: begin
                send_str("Message-Type:");
                if ($urandom_range(0, 1))
                    send_byte(CH_SPACE, 1'b1);
                n = $urandom_range(0, 9);
                if (n == 0)
                    n = 0;
                else if (n == 1)
                    n = MAX_TYPE_LEN - 1 + $urandom_range(0, 5);
                else
                    n = $urandom_range(1, 6);
                repeat (n) send_byte(text_byte(), 1'b1);
            end
            LN_LENGTH: begin
                send_str("Content-Length:");
                if ($urandom_range(0, 1))
                    send_byte(CH_SPACE, 1'b1);
                case ($urandom_range(0, 19))
                    0:       val = "0";
                    1:       val = "4294967296";
                    2:       val = "99999999999";
                    3:       val = "+7";
                    4:       val = "";
                    5:       val = " 9";
                    6:       val = $sformatf("%0dx7", $urandom_range(1, 16));
                    7:       val = $sformatf("00%0d", $urandom_range(1, 16));
                    default: val = $sformatf("%0d", $urandom_range(1, 16));
                endcase
                send_str(val);
            end
            LN_NEAR: begin
                send_str(near_names[$urandom_range(0, 5)]);
                send_byte(CH_COLON, 1'b1);
                repeat ($urandom_range(0, 4)) send_byte(text_byte(), 1'b1);
            end
            LN_JUNK: begin
                repeat ($urandom_range(1, 10)) begin
                    v = text_byte();
                    if (v == CH_COLON)
                        v = 8'h3B;
                    send_byte(v, 1'b1);
                end
            end
            default: begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b1);
            end
        endcase
        send_byte(CH_LF, 1'b1);
    endtask

    task automatic random_frame();
        line_e lines [$];
        repeat ($urandom_range(0, 2)) send_byte(CH_LF, 1'b1);
        if ($urandom_range(0, 99) < 85)
            lines.push_back(LN_TYPE);
        if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 1))
                lines.push_front(LN_LENGTH);
            else
                lines.push_back(LN_LENGTH);
        end
        if ($urandom_range(0, 99) < 40)
            lines.insert($urandom_range(0, lines.size()), line_e'($urandom_range(LN_NEAR, LN_NOISE)));
        foreach (lines[i]) send_line(lines[i]);
        send_byte(CH_LF, 1'b1);
        while (hdr_phase == PH_BODY)
            send_byte(8'($urandom), 1'b1);
        frames++;
    endtask

    task automatic report(input string what, input deframe_out_t want, input deframe_out_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s: expected kind=%0d byte=%02h last=%0d trunc=%0d, got kind=%0d byte=%02h last=%0d trunc=%0d pad=%02h",
                     what, want.kind, want.data, want.last, want.trunc,
                     got.kind, got.data, got.last, got.trunc, m_tdata[15:9]);
    endtask

    always @(posedge aclk) begin
        deframe_out_t got;
        deframe_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind: m_tuser, data: m_tdata[7:0], last: m_tlast, trunc: m_tdata[8]};
            if (got.kind)
                body_seen++;
            else
                type_seen++;
            if (pending_out.size() == 0) begin
                report("unexpected result", '0, got);
            end else begin
                want = pending_out[0];
                pending_out.delete(0);
                if (got != want || m_tdata[15:9] != '0)
                    report("mismatch", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        rx_tick++;
        if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_e'($urandom_range(RX_OPEN, RX_PATTERN));
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                default:   m_tready <= (rx_tick % 3) != 0;
            endcase
        end
    end

    initial begin
        bit held;
        held = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (PROBE_TAB[i])
            send_byte(PROBE_TAB[i].rx, !PROBE_TAB[i].quiet);

        in_random = 1'b1;
        while (rand_reqs < RANDOM_REQS) begin
            if (!held && rand_reqs >= HOLD_AT) begin
                held = 1'b1;
                while (hdr_phase != PH_IDLE)
                    send_byte(hdr_phase == PH_BODY ? 8'($urandom) : CH_LF, 1'b1);
                // stall the sink through an overflowing type and a long body
                hold_go = 1'b1;
                send_str("Message-Type:");
                repeat (MAX_TYPE_LEN + 3) send_byte(text_byte(), 1'b1);
                send_str("\nContent-Length:40\n\n");
                while (hdr_phase == PH_BODY)
                    send_byte(8'($urandom), 1'b1);
                frames++;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_out.size() != 0);
            end
            random_frame();
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_out.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d directed, %0d in %0d random frames",
                 dir_reqs + rand_reqs, dir_reqs, rand_reqs, frames);
        $display("Checked %0d type bytes and %0d body bytes, %0d mismatches",
                 type_seen, body_seen, mismatches);
        if (mismatches == 0 && pending_out.size() == 0)
            $display("PASS header_length_message_deframer");
        else
            $display("FAIL header_length_message_deframer");
        $finish;
    end

endmodule
